@@ rtl/core/srsw_pkg.sv @@
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared codes for the selective-repeat sender window: request codes,
// ack status codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  // Request codes carried in the operation field
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Ack status codes
  localparam logic [1:0] ST_ADVANCED = 2'd0;
  localparam logic [1:0] ST_BUFFERED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_BAD_CKSUM = 2'd3;

  // Window register
  localparam int unsigned WIN_W     = 3;
  localparam logic [2:0]  WIN_RESET = 3'd4;
  localparam int unsigned WIN_MAX   = 7;   // largest value the register holds

  // Register word index (paddr[2])
  localparam logic REG_WINDOW = 1'b0;

  typedef logic [WIN_W-1:0] win_t;

endpackage

`default_nettype wire

@@ rtl/core/srsw_ram.sv @@
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/selective_repeat_sender_window.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat ARQ link: holds the outstanding packets,
// tracks buffered acks, slides the window base and drives timer requests.
//
//   channel | direction | handshake          | carries
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_ready  | one request: send, ack, timeout
//   out_    | output    | out_valid/out_ready| one result per request
//   APB     | input     | psel/penable/...   | window_size register (word 0)
//
// Each request is captured in S_IDLE, which also starts the payload RAM read,
// and is evaluated in S_EXEC, which writes back state and the result
// register. A new request is taken once the previous one has been evaluated.
// If the result register is still held by out_ready low, evaluation waits.
// Reset (synchronous, rst_n low) empties the window, clears all ack marks and
// sets window_size to 4; the payload RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int unsigned SEQ_SPACE     = 8,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [PAYLOAD_WIDTH-1:0]     in_payload,
  input  wire logic [$clog2(SEQ_SPACE)-1:0] in_ack_num,
  input  wire logic                         in_checksum_ok,
  input  wire logic [$clog2(SEQ_SPACE)-1:0] in_timeout_seq,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_accepted,
  output logic                              out_tx_valid,
  output logic [$clog2(SEQ_SPACE)-1:0]      out_tx_seq,
  output logic [PAYLOAD_WIDTH-1:0]          out_tx_payload,
  output logic                              out_timer_stop,
  output logic                              out_timer_start,
  output logic [$clog2(SEQ_SPACE)-1:0]      out_timer_seq,
  output logic [1:0]                        out_ack_status,
  output logic                              out_window_full,
  output logic [$clog2(SEQ_SPACE)-1:0]      out_base_seq,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int unsigned SEQ_W = $clog2(SEQ_SPACE);
  localparam int unsigned CW    = SEQ_W + 1;
  localparam int unsigned HALF  = SEQ_SPACE / 2;
  localparam int unsigned LOOK  = (HALF < WIN_MAX) ? HALF : WIN_MAX;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CW-1:0]    cnt_t;

  // sequence number plus a small offset, modulo the sequence space
  function automatic seq_t seq_add(input seq_t s, input cnt_t k);
    cnt_t sum;
    sum = cnt_t'(s) + k;
    if (sum >= cnt_t'(SEQ_SPACE)) begin
      sum = sum - cnt_t'(SEQ_SPACE);
    end
    return sum[SEQ_W-1:0];
  endfunction

  // packets outstanding between base and next
  function automatic cnt_t span(input seq_t b, input seq_t n);
    cnt_t d;
    if (n >= b) begin
      d = cnt_t'(n) - cnt_t'(b);
    end else begin
      d = cnt_t'(n) + cnt_t'(SEQ_SPACE) - cnt_t'(b);
    end
    return d;
  endfunction

  // membership in [b, n) with wrap
  function automatic logic in_win(input seq_t s, input seq_t b, input seq_t n);
    logic hit;
    if (cnt_t'(s) >= cnt_t'(SEQ_SPACE)) begin
      hit = 1'b0;
    end else if (b <= n) begin
      hit = (s >= b) && (s < n);
    end else begin
      hit = (s >= b) || (s < n);
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic                     state_r, state_nxt;
  win_t                     win_r;
  seq_t                     base_r, base_nxt;
  seq_t                     next_r, next_nxt;
  logic [SEQ_SPACE-1:0]     acked_r, acked_nxt;

  logic [1:0]               op_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  seq_t                     ackn_r;
  logic                     cks_r;
  seq_t                     tseq_r;

  logic                     ov_r, ov_nxt;
  logic                     acc_r, acc_nxt;
  logic                     txv_r, txv_nxt;
  seq_t                     txs_r, txs_nxt;
  logic [PAYLOAD_WIDTH-1:0] txp_r, txp_nxt;
  logic                     tstop_r, tstop_nxt;
  logic                     tstart_r, tstart_nxt;
  seq_t                     tsq_r, tsq_nxt;
  logic [1:0]               stat_r, stat_nxt;
  logic                     full_r, full_nxt;
  seq_t                     bout_r, bout_nxt;

  logic                     in_fire;
  logic                     exec_go;
  logic                     ram_we;
  logic [PAYLOAD_WIDTH-1:0] ram_rdata;
  logic                     cfg_wr;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && (!ov_r || out_ready);

  // --------------------------------------------------------------------------
  // Payload store
  // --------------------------------------------------------------------------
  srsw_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (SEQ_SPACE)
  ) u_pay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_r),
    .wdata (pay_r),
    .re    (in_fire),
    .raddr (in_timeout_seq),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
  assign prdata = (paddr[2] == REG_WINDOW) ? {{(32-WIN_W){1'b0}}, win_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (cfg_wr) begin
      win_r <= pwdata[WIN_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Request evaluation
  // --------------------------------------------------------------------------
  cnt_t                 eff_w;
  cnt_t                 out_cnt;
  logic [SEQ_SPACE-1:0] marks_set;
  seq_t                 pos [LOOK];
  cnt_t                 run_len;
  logic                 run;
  logic                 ack_in;
  logic                 tmo_hit;
  seq_t                 slid_base;

  always_comb begin
    // effective window: 0 acts as 1, clamp at half the sequence space
    eff_w = cnt_t'(win_r);
    if (eff_w == cnt_t'(0)) begin
      eff_w = cnt_t'(1);
    end
    if (eff_w > cnt_t'(HALF)) begin
      eff_w = cnt_t'(HALF);
    end

    out_cnt = span(base_r, next_r);
    ack_in  = in_win(ackn_r, base_r, next_r);
    tmo_hit = in_win(tseq_r, base_r, next_r) && !acked_r[tseq_r];

    // marks with the arriving ack applied
    marks_set = acked_r;
    if (ack_in) begin
      marks_set[ackn_r] = 1'b1;
    end

    // run of contiguous acks starting at base
    run     = 1'b1;
    run_len = '0;
    for (int k = 0; k < LOOK; k++) begin
      pos[k] = seq_add(base_r, cnt_t'(k));
      if (run && (cnt_t'(k) < out_cnt) && marks_set[pos[k]]) begin
        run_len = run_len + cnt_t'(1);
      end else begin
        run = 1'b0;
      end
    end
    slid_base = seq_add(base_r, run_len);

    // defaults
    state_nxt  = state_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    acked_nxt  = acked_r;
    ram_we     = 1'b0;
    ov_nxt     = ov_r && !out_ready;
    acc_nxt    = acc_r;
    txv_nxt    = txv_r;
    txs_nxt    = txs_r;
    txp_nxt    = txp_r;
    tstop_nxt  = tstop_r;
    tstart_nxt = tstart_r;
    tsq_nxt    = tsq_r;
    stat_nxt   = stat_r;
    full_nxt   = full_r;
    bout_nxt   = bout_r;

    if (in_fire) begin
      state_nxt = S_EXEC;
    end

    if (exec_go) begin
      state_nxt  = S_IDLE;
      ov_nxt     = 1'b1;
      acc_nxt    = 1'b0;
      txv_nxt    = 1'b0;
      txs_nxt    = '0;
      txp_nxt    = '0;
      tstop_nxt  = 1'b0;
      tstart_nxt = 1'b0;
      tsq_nxt    = '0;
      stat_nxt   = ST_ADVANCED;

      case (op_r)
        OP_SEND: begin
          if (out_cnt < eff_w) begin
            ram_we            = 1'b1;
            acked_nxt[next_r] = 1'b0;
            acc_nxt           = 1'b1;
            txv_nxt           = 1'b1;
            txs_nxt           = next_r;
            txp_nxt           = pay_r;
            if (base_r == next_r) begin
              tstart_nxt = 1'b1;
              tsq_nxt    = next_r;
            end
            next_nxt = seq_add(next_r, cnt_t'(1));
          end
        end
        OP_ACK: begin
          if (!cks_r) begin
            stat_nxt = ST_BAD_CKSUM;
          end else if (!ack_in) begin
            stat_nxt = ST_OUTSIDE;
          end else begin
            acc_nxt   = 1'b1;
            tstop_nxt = 1'b1;
            acked_nxt = marks_set;
            if (ackn_r == base_r) begin
              stat_nxt = ST_ADVANCED;
              for (int k = 0; k < LOOK; k++) begin
                if (cnt_t'(k) < run_len) begin
                  acked_nxt[pos[k]] = 1'b0;
                end
              end
              base_nxt = slid_base;
            end else begin
              stat_nxt = ST_BUFFERED;
            end
            if (base_nxt != next_r) begin
              tstart_nxt = 1'b1;
              tsq_nxt    = base_nxt;
            end
          end
        end
        OP_TIMEOUT: begin
          if (tmo_hit) begin
            txv_nxt    = 1'b1;
            txs_nxt    = tseq_r;
            txp_nxt    = ram_rdata;
            tstop_nxt  = 1'b1;
            tstart_nxt = 1'b1;
            tsq_nxt    = tseq_r;
          end
        end
        default: begin
        end
      endcase

      full_nxt = (span(base_nxt, next_nxt) >= eff_w);
      bout_nxt = base_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= '0;
      next_r  <= '0;
      acked_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      acked_r <= acked_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // captured request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_operation;
      pay_r  <= in_payload;
      ackn_r <= in_ack_num;
      cks_r  <= in_checksum_ok;
      tseq_r <= in_timeout_seq;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    txv_r    <= txv_nxt;
    txs_r    <= txs_nxt;
    txp_r    <= txp_nxt;
    tstop_r  <= tstop_nxt;
    tstart_r <= tstart_nxt;
    tsq_r    <= tsq_nxt;
    stat_r   <= stat_nxt;
    full_r   <= full_nxt;
    bout_r   <= bout_nxt;
  end

  assign out_valid       = ov_r;
  assign out_accepted    = acc_r;
  assign out_tx_valid    = txv_r;
  assign out_tx_seq      = txs_r;
  assign out_tx_payload  = txp_r;
  assign out_timer_stop  = tstop_r;
  assign out_timer_start = tstart_r;
  assign out_timer_seq   = tsq_r;
  assign out_ack_status  = stat_r;
  assign out_window_full = full_r;
  assign out_base_seq    = bout_r;

endmodule

`default_nettype wire

@@ test/selective_repeat_sender_window_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_tb
// Self-checking bench for the selective-repeat sender window. A behavioral
// window model predicts each result and compares it with the DUT output.
// The stimulus covers sends, acks and timeouts across all window register
// settings. It starts with a directed walk through the corner cases. After
// that it runs random traffic with gaps on both channels.
// ----------------------------------------------------------------------------

module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  localparam int unsigned SEQ_W     = 3;
  localparam int unsigned PAY_W     = 32;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int unsigned LIMIT     = 200_000;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [PAY_W-1:0] payload;
    seq_t             ack_num;
    logic             checksum_ok;
    seq_t             timeout_seq;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             tx_valid;
    seq_t             tx_seq;
    logic [PAY_W-1:0] tx_payload;
    logic             timer_stop;
    logic             timer_start;
    seq_t             timer_seq;
    logic [1:0]       ack_status;
    logic             window_full;
    seq_t             base_seq;
  } rsp_t;

  // DUT signals
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_operation = '0;
  logic [PAY_W-1:0] in_payload = '0;
  seq_t             in_ack_num = '0;
  logic             in_checksum_ok = 1'b0;
  seq_t             in_timeout_seq = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_accepted;
  logic             out_tx_valid;
  seq_t             out_tx_seq;
  logic [PAY_W-1:0] out_tx_payload;
  logic             out_timer_stop;
  logic             out_timer_start;
  seq_t             out_timer_seq;
  logic [1:0]       out_ack_status;
  logic             out_window_full;
  seq_t             out_base_seq;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Window model state
  win_t             win_q;
  seq_t             base_q;
  seq_t             next_q;
  logic             acked_q [8];
  logic [PAY_W-1:0] store_q [8];

  rsp_t             due_results[$];
  int unsigned      errors = 0;
  int unsigned      cycle_count = 0;
  bit               calm = 1'b0;

  selective_repeat_sender_window u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_payload     (in_payload),
    .in_ack_num     (in_ack_num),
    .in_checksum_ok (in_checksum_ok),
    .in_timeout_seq (in_timeout_seq),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_tx_valid   (out_tx_valid),
    .out_tx_seq     (out_tx_seq),
    .out_tx_payload (out_tx_payload),
    .out_timer_stop (out_timer_stop),
    .out_timer_start(out_timer_start),
    .out_timer_seq  (out_timer_seq),
    .out_ack_status (out_ack_status),
    .out_window_full(out_window_full),
    .out_base_seq   (out_base_seq),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Window model
  // ---------------------------------------------------------------------------
  function automatic seq_t eff_window();
    if (win_q == 0) return 3'd1;
    if (win_q > 4) return 3'd4;
    return seq_t'(win_q);
  endfunction

  function automatic logic in_flight(seq_t s);
    return seq_t'(s - base_q) < seq_t'(next_q - base_q);
  endfunction

  function automatic rsp_t window_step(req_t r);
    rsp_t o;
    seq_t outs;
    o = '0;
    outs = seq_t'(next_q - base_q);
    case (r.op)
      OP_SEND: begin
        if (outs < eff_window()) begin
          store_q[next_q] = r.payload;
          acked_q[next_q] = 1'b0;
          o.accepted   = 1'b1;
          o.tx_valid   = 1'b1;
          o.tx_seq     = next_q;
          o.tx_payload = r.payload;
          if (outs == 0) begin
            o.timer_start = 1'b1;
            o.timer_seq   = next_q;
          end
          next_q = next_q + 3'd1;
        end
      end
      OP_ACK: begin
        if (!r.checksum_ok) begin
          o.ack_status = ST_BAD_CKSUM;
        end else if (!in_flight(r.ack_num)) begin
          o.ack_status = ST_OUTSIDE;
        end else begin
          o.accepted   = 1'b1;
          o.timer_stop = 1'b1;
          acked_q[r.ack_num] = 1'b1;
          if (r.ack_num == base_q) begin
            o.ack_status = ST_ADVANCED;
            // slide over every contiguous acked number
            while (base_q != next_q && acked_q[base_q]) begin
              acked_q[base_q] = 1'b0;
              base_q = base_q + 3'd1;
            end
          end else begin
            o.ack_status = ST_BUFFERED;
          end
          if (base_q != next_q) begin
            o.timer_start = 1'b1;
            o.timer_seq   = base_q;
          end
        end
      end
      OP_TIMEOUT: begin
        if (in_flight(r.timeout_seq) && !acked_q[r.timeout_seq]) begin
          o.tx_valid    = 1'b1;
          o.tx_seq      = r.timeout_seq;
          o.tx_payload  = store_q[r.timeout_seq];
          o.timer_stop  = 1'b1;
          o.timer_start = 1'b1;
          o.timer_seq   = r.timeout_seq;
        end
      end
      default: ;
    endcase
    o.window_full = seq_t'(next_q - base_q) >= eff_window();
    o.base_seq    = base_q;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH %0d: %s", errors, msg);
  endtask

  function automatic string rsp_text(rsp_t r);
    return $sformatf({"acc=%0b txv=%0b txs=%0d txp=%h stop=%0b start=%0b tseq=%0d ",
                      "st=%0d full=%0b base=%0d"},
                     r.accepted, r.tx_valid, r.tx_seq, r.tx_payload, r.timer_stop,
                     r.timer_start, r.timer_seq, r.ack_status, r.window_full, r.base_seq);
  endfunction

  always @(posedge clk) begin
    rsp_t got;
    rsp_t exp;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_accepted, out_tx_valid, out_tx_seq, out_tx_payload, out_timer_stop,
              out_timer_start, out_timer_seq, out_ack_status, out_window_full,
              out_base_seq};
      if (due_results.size() == 0) begin
        note_error({"unexpected result ", rsp_text(got)});
      end else begin
        exp = due_results.pop_front();
        if (got !== exp)
          note_error({"expected ", rsp_text(exp), " | actual ", rsp_text(got)});
      end
    end
  end

  // Result-side stalls in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request and register access
  // ---------------------------------------------------------------------------
  // Drive one request and hold it until the transfer; valid is left high so
  // back-to-back requests need no extra edge.
  task automatic send_item(req_t r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= r.op;
    in_payload     <= r.payload;
    in_ack_num     <= r.ack_num;
    in_checksum_ok <= r.checksum_ok;
    in_timeout_seq <= r.timeout_seq;
    do @(posedge clk); while (!in_ready);
    due_results = {due_results, window_step(r)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // Write the window register while idle, then read it back
  task automatic set_window(logic [2:0] w);
    logic [31:0] value;
    value = $urandom;
    value[2:0] = w;
    drain_results();
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    win_q = w;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[2:0] !== w)
      note_error($sformatf("window readback expected %0d actual %0d", w, prdata[2:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic req_t mk_req(logic [1:0] op, logic [PAY_W-1:0] payload, seq_t ack_num,
                                  logic checksum_ok, seq_t timeout_seq);
    return '{op, payload, ack_num, checksum_ok, timeout_seq};
  endfunction

  // Mostly well-formed traffic aimed at the live window, plus noise
  function automatic req_t pick_request();
    req_t r;
    seq_t outs;
    int unsigned roll;
    r = mk_req(OP_SEND, $urandom, seq_t'($urandom), 1'($urandom), seq_t'($urandom));
    outs = seq_t'(next_q - base_q);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      r.op = OP_SEND;
      case ($urandom_range(0, 9))
        0:       r.payload = '0;
        1:       r.payload = '1;
        default: r.payload = $urandom;
      endcase
    end else if (roll < 70) begin
      r.op = OP_ACK;
      r.checksum_ok = 1'b1;
      if (outs != 0)
        r.ack_num = ($urandom_range(0, 2) == 0) ? base_q :
                    seq_t'(base_q + seq_t'($urandom_range(0, outs - 1)));
    end else if (roll < 82) begin
      r.op = OP_TIMEOUT;
      if (outs != 0) r.timeout_seq = seq_t'(base_q + seq_t'($urandom_range(0, outs - 1)));
    end else if (roll < 88) begin
      r.op = OP_ACK;
      r.checksum_ok = 1'b0;
    end else if (roll < 94) begin
      r.op = OP_ACK;
    end else if (roll < 97) begin
      r.op = OP_TIMEOUT;
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic random_items(int unsigned n);
    req_t r;
    int unsigned done;
    done = 0;
    while (done < n) begin
      r = pick_request();
      send_item(r);
      if (r.op != OP_UNUSED) done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty-window requests, fill to full, refusal, acks of every kind and
  // timeouts for live, acked and idle numbers
  task automatic test_directed();
    send_item(mk_req(OP_TIMEOUT, '0, 3'd0, 1'b1, 3'd0));
    send_item(mk_req(OP_ACK, '0, 3'd0, 1'b1, 3'd0));
    send_item(mk_req(OP_UNUSED, '1, 3'd7, 1'b1, 3'd7));
    send_item(mk_req(OP_SEND, 32'h0000_0000, 3'd0, 1'b0, 3'd0));
    send_item(mk_req(OP_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7));
    send_item(mk_req(OP_SEND, 32'hA5A5_A5A5, 3'd0, 1'b0, 3'd0));
    send_item(mk_req(OP_SEND, 32'h5A5A_5A5A, 3'd0, 1'b0, 3'd0));
    send_item(mk_req(OP_SEND, 32'h1234_5678, 3'd0, 1'b0, 3'd0));
    send_item(mk_req(OP_ACK, '0, 3'd0, 1'b0, 3'd0));
    send_item(mk_req(OP_ACK, '0, 3'd2, 1'b1, 3'd0));
    send_item(mk_req(OP_ACK, '0, 3'd2, 1'b1, 3'd0));
    send_item(mk_req(OP_TIMEOUT, '0, 3'd0, 1'b1, 3'd2));
    send_item(mk_req(OP_TIMEOUT, '0, 3'd0, 1'b1, 3'd1));
    send_item(mk_req(OP_TIMEOUT, '0, 3'd0, 1'b1, 3'd7));
    send_item(mk_req(OP_ACK, '0, 3'd1, 1'b1, 3'd0));
    send_item(mk_req(OP_ACK, '0, 3'd0, 1'b1, 3'd0));
    send_item(mk_req(OP_TIMEOUT, '0, 3'd0, 1'b1, 3'd3));
    send_item(mk_req(OP_ACK, '0, 3'd3, 1'b1, 3'd0));
    send_item(mk_req(OP_ACK, '0, 3'd4, 1'b1, 3'd0));
    send_item(mk_req(OP_SEND, 32'hC0DE_0001, 3'd0, 1'b1, 3'd0));
  endtask

  // Shrink the window under a full set of outstanding packets
  task automatic test_window_shrink();
    repeat (4) send_item(mk_req(OP_SEND, $urandom, seq_t'($urandom), 1'b1, seq_t'($urandom)));
    set_window(3'd1);
    random_items(40);
  endtask

  // Every register value but 1, out-of-range ones included
  task automatic test_window_settings();
    logic [2:0] sweep [7] = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};
    foreach (sweep[i]) begin
      set_window(sweep[i]);
      random_items(60);
    end
  endtask

  // Sender holds off until the result queue is empty
  task automatic test_drain_pause();
    random_items(80);
    drain_results();
    random_items(80);
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    calm = 1'b1;
    random_items(150);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    win_q  = WIN_RESET;
    base_q = '0;
    next_q = '0;
    foreach (acked_q[i]) begin
      acked_q[i] = 1'b0;
      store_q[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_window_shrink();
    test_window_settings();
    test_drain_pause();
    test_steady_stream();

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
